// ===== sv/srdc_pkg.sv =====
// Shared types, constants and the CRC byte update for the state record decoder checker.
`default_nettype none

package srdc_pkg;

  localparam int unsigned PosW = 6;

  localparam logic [31:0]     RecordMagic = 32'h3153_5452;
  localparam logic [31:0]     CrcPoly     = 32'hEDB8_8320;
  localparam logic [31:0]     CrcInit     = 32'hFFFF_FFFF;
  localparam logic [PosW-1:0] CrcSpan     = 6'd36;
  localparam logic [PosW-1:0] RecordLen   = 6'd40;
  localparam logic [PosW-1:0] CountCap    = 6'd41;
  localparam logic [PosW-1:0] OffsetBase  = 6'd12;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StLength  = 3'd1,
    StMagic   = 3'd2,
    StVersion = 3'd3,
    StCrc     = 3'd4,
    StMode    = 3'd5
  } status_e;

  typedef enum logic {
    RegExpectedVersion = 1'b0,
    RegMaxModeValue    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]      data;
    logic [PosW-1:0] pos;
    logic            last;
  } item_t;

  typedef struct packed {
    logic [7:0] expected_version;
    logic [7:0] max_mode_value;
  } cfg_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] layout_revision;
    logic [31:0] flag_bits;
    logic [31:0] page_number;
    logic [31:0] node_offset;
    logic [63:0] byte_offset;
    logic [31:0] chapter;
    logic [7:0]  font_scale;
    logic [7:0]  orientation;
    logic [7:0]  counter_mode;
    status_e     status;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'h0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/state_record_decoder_checker.sv =====
// Top level of the saved reader-state record decoder and checker.
`default_nettype none

// Takes one record byte per cycle on the input stream, with tlast on the final
// byte, and gives one result word per record: a status code and, when the
// status is ok, the decoded fields (zero otherwise). A byte enters every cycle
// while the queue has room; the back end consumes one queued byte per cycle,
// but holds a last byte while an untaken result fills the output register,
// so the sustained rate is one byte per cycle while results are taken. The
// result register, loaded as a record's last byte leaves the queue, lets the
// next record stream in. Config writes take effect at the next clock edge.
module state_record_decoder_checker #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire          cfg_idx_i,
  input  wire  [7:0]   cfg_data_i,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [7:0]   s_axis_tdata,   // data_byte
  input  wire          s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // status, counter_mode, orientation, font_scale, chapter, byte_offset,
  // node_offset, page_number, flag_bits, layout_revision, zero fill
  output logic [255:0] m_axis_tdata
);

  srdc_pkg::cfg_t    cfg_q;
  srdc_pkg::item_t   push_item, pop_item;
  srdc_pkg::result_t out_data;
  logic              push_valid, push_ready, pop_valid, pop_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_version <= 8'd1;
      cfg_q.max_mode_value   <= 8'd2;
    end else if (cfg_we_i) begin
      unique case (srdc_pkg::reg_idx_e'(cfg_idx_i))
        srdc_pkg::RegExpectedVersion: cfg_q.expected_version <= cfg_data_i;
        srdc_pkg::RegMaxModeValue:    cfg_q.max_mode_value   <= cfg_data_i;
        default:                      cfg_q                  <= cfg_q;
      endcase
    end
  end

  srdc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  srdc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  srdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_ready_o (pop_ready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_data),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = out_data;

  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> pop_valid)
    else $error("accepted byte not queued");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready && pop_item.last) |=> m_axis_tvalid)
    else $error("last byte gave no result");

  a_fail_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_data.status != srdc_pkg::StOk)) |-> (m_axis_tdata[255:3] == '0))
    else $error("failed record carries field data");

endmodule

`default_nettype wire

// ===== sv/srdc_front.sv =====
// Front end: accepts record bytes and tags each with its position in the record.
`default_nettype none

module srdc_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire  [7:0]          in_byte_i,
  input  wire                 in_last_i,
  output logic                in_ready_o,
  output logic                push_valid_o,
  output srdc_pkg::item_t     push_item_o,
  input  wire                 push_ready_i
);

  logic [srdc_pkg::PosW-1:0] count_q, count_d;
  logic                      accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  assign push_item_o.data = in_byte_i;
  assign push_item_o.pos  = count_q;
  assign push_item_o.last = in_last_i;

  // restart on the last byte, saturate past the record length
  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (in_last_i) begin
        count_d = '0;
      end else if (count_q < srdc_pkg::CountCap) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/srdc_queue.sv =====
// Small FIFO of tagged bytes between the front end and the back end.
`default_nettype none

module srdc_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_valid_i,
  input  srdc_pkg::item_t     push_item_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output srdc_pkg::item_t     pop_item_o,
  input  wire                 pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  srdc_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/srdc_back.sv =====
// Back end: CRC, field assembly, record checks and the result register.
`default_nettype none

module srdc_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  srdc_pkg::cfg_t      cfg_i,
  input  wire                 pop_valid_i,
  input  srdc_pkg::item_t     pop_item_i,
  output logic                pop_ready_o,
  output logic                out_valid_o,
  output srdc_pkg::result_t   out_data_o,
  input  wire                 out_ready_i
);

  logic [31:0] crc_q, crc_d, magic_q, magic_d, chapter_q, chapter_d;
  logic [31:0] node_q, node_d, page_q, page_d, flags_q, flags_d;
  logic [31:0] layout_q, layout_d, scrc_q, scrc_d;
  logic [63:0] boff_q, boff_d;
  logic [7:0]  version_q, version_d, mode_q, mode_d;
  logic [7:0]  orient_q, orient_d, font_q, font_d;

  logic                      out_valid_q, out_valid_d;
  srdc_pkg::result_t         out_data_q, result;
  srdc_pkg::status_e         status;
  logic [7:0]                b;
  logic [srdc_pkg::PosW-1:0] pos, rel;
  logic                      pop, pop_last;

  assign b   = pop_item_i.data;
  assign pos = pop_item_i.pos;
  assign rel = pos - srdc_pkg::OffsetBase;

  assign pop_ready_o = !pop_item_i.last || !out_valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;
  assign pop_last    = pop && pop_item_i.last;

  // place the byte by its position
  always_comb begin
    crc_d     = crc_q;
    magic_d   = magic_q;
    version_d = version_q;
    mode_d    = mode_q;
    orient_d  = orient_q;
    font_d    = font_q;
    chapter_d = chapter_q;
    boff_d    = boff_q;
    node_d    = node_q;
    page_d    = page_q;
    flags_d   = flags_q;
    layout_d  = layout_q;
    scrc_d    = scrc_q;
    if (pos < srdc_pkg::CrcSpan) begin
      crc_d = srdc_pkg::crc_byte(crc_q, b);
    end
    priority if (pos < 6'd4) begin
      magic_d[{pos[1:0], 3'b000} +: 8] = b;
    end else if (pos == 6'd4) begin
      version_d = b;
    end else if (pos == 6'd5) begin
      mode_d = b;
    end else if (pos == 6'd6) begin
      orient_d = b;
    end else if (pos == 6'd7) begin
      font_d = b;
    end else if (pos < 6'd12) begin
      chapter_d[{pos[1:0], 3'b000} +: 8] = b;
    end else if (pos < 6'd20) begin
      boff_d[{rel[2:0], 3'b000} +: 8] = b;
    end else if (pos < 6'd24) begin
      node_d[{pos[1:0], 3'b000} +: 8] = b;
    end else if (pos < 6'd28) begin
      page_d[{pos[1:0], 3'b000} +: 8] = b;
    end else if (pos < 6'd32) begin
      flags_d[{pos[1:0], 3'b000} +: 8] = b;
    end else if (pos < 6'd36) begin
      layout_d[{pos[1:0], 3'b000} +: 8] = b;
    end else if (pos < srdc_pkg::RecordLen) begin
      scrc_d[{pos[1:0], 3'b000} +: 8] = b;
    end else begin
      scrc_d = scrc_q;
    end
  end

  // first failing check wins
  always_comb begin
    priority if (pos != srdc_pkg::RecordLen - 1'b1) begin
      status = srdc_pkg::StLength;
    end else if (magic_d != srdc_pkg::RecordMagic) begin
      status = srdc_pkg::StMagic;
    end else if (version_d != cfg_i.expected_version) begin
      status = srdc_pkg::StVersion;
    end else if (scrc_d != ~crc_d) begin
      status = srdc_pkg::StCrc;
    end else if (mode_d > cfg_i.max_mode_value) begin
      status = srdc_pkg::StMode;
    end else begin
      status = srdc_pkg::StOk;
    end
  end

  always_comb begin
    result        = '0;
    result.status = status;
    if (status == srdc_pkg::StOk) begin
      result.counter_mode    = mode_d;
      result.orientation     = orient_d;
      result.font_scale      = font_d;
      result.chapter         = chapter_d;
      result.byte_offset     = boff_d;
      result.node_offset     = node_d;
      result.page_number     = page_d;
      result.flag_bits       = flags_d;
      result.layout_revision = layout_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      crc_q       <= srdc_pkg::CrcInit;
      magic_q     <= '0;
      version_q   <= '0;
      mode_q      <= '0;
      orient_q    <= '0;
      font_q      <= '0;
      chapter_q   <= '0;
      boff_q      <= '0;
      node_q      <= '0;
      page_q      <= '0;
      flags_q     <= '0;
      layout_q    <= '0;
      scrc_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_last) begin
        crc_q     <= srdc_pkg::CrcInit;
        magic_q   <= '0;
        version_q <= '0;
        mode_q    <= '0;
        orient_q  <= '0;
        font_q    <= '0;
        chapter_q <= '0;
        boff_q    <= '0;
        node_q    <= '0;
        page_q    <= '0;
        flags_q   <= '0;
        layout_q  <= '0;
        scrc_q    <= '0;
      end else if (pop) begin
        crc_q     <= crc_d;
        magic_q   <= magic_d;
        version_q <= version_d;
        mode_q    <= mode_d;
        orient_q  <= orient_d;
        font_q    <= font_d;
        chapter_q <= chapter_d;
        boff_q    <= boff_d;
        node_q    <= node_d;
        page_q    <= page_d;
        flags_q   <= flags_d;
        layout_q  <= layout_d;
        scrc_q    <= scrc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_last) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
